// ===== src/rsmp_pkg.sv =====
// Shared types, constants and codes for the reservoir sampler.
package rsmp_pkg;

    localparam int RES_DEPTH = 64;
    localparam int ADDR_W    = $clog2(RES_DEPTH);
    localparam int CNT_W     = $clog2(RES_DEPTH + 1);
    localparam int CFG_W     = 7;
    localparam int ITEM_W    = 64;
    localparam int RND_W     = 31;
    localparam int SEEN_W    = 32;
    localparam int STEP_W    = $clog2(RND_W);
    localparam int IN_DATA_W = ((ITEM_W + RND_W + 7) / 8) * 8;

    localparam logic [CFG_W-1:0]  SAMPLE_RESET = CFG_W'(1);
    localparam logic [STEP_W-1:0] LAST_STEP    = STEP_W'(RND_W - 1);

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_REPL,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic take;
        logic div_step;
        logic replace;
        logic flush_load;
        logic flush_end;
    } cmd_t;

    typedef struct packed {
        logic fill_lt_cap;
        logic div_last;
        logic out_free;
        logic flush_last;
    } status_t;

endpackage

// ===== src/reservoir_sampler_unit.sv =====
// Top level of the reservoir sampler: stream ports, configuration port, controller and datapath.
// A push word that lands in a free slot is written directly; once the reservoir is full a push
// runs the 31-step radix-2 divider that reduces the random word modulo the seen count and
// then writes the chosen slot. A flush emits one output word per
// cycle from the reservoir memory (fill count words, or one empty word), paced by m_axis_tready.
// The configuration register is always ready and should be written only while the block is idle.
module reservoir_sampler_unit
    import rsmp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,   // item_value, random_word, zero pad
    input  logic                 s_axis_tuser,   // op
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [ITEM_W-1:0]    m_axis_tdata,   // item_value_res
    output logic                 m_axis_tuser,   // valid_res
    output logic                 m_axis_tlast
);

    cmd_t    cmd;
    status_t status;
    logic    unused_pad;

    assign cfg_ready  = 1'b1;
    assign unused_pad = ^s_axis_tdata[IN_DATA_W-1:ITEM_W+RND_W];

    rsmp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rsmp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_wdata (cfg_data),
        .in_op     (s_axis_tuser),
        .in_item   (s_axis_tdata[ITEM_W-1:0]),
        .in_rnd    (s_axis_tdata[ITEM_W+RND_W-1:ITEM_W]),
        .cmd       (cmd),
        .status    (status),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_item  (m_axis_tdata),
        .out_flag  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule

// ===== src/rsmp_ctrl.sv =====
// Controller state machine for the reservoir sampler.
module rsmp_ctrl
    import rsmp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_op,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (in_op == OP_FLUSH)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else if (!status.fill_lt_cap)
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_REPL;
                end
            end
            ST_REPL:
            begin
                cmd.replace = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_FLUSH:
            begin
                if (status.out_free)
                begin
                    cmd.flush_load = 1'b1;
                    if (status.flush_last)
                    begin
                        cmd.flush_end = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/rsmp_dp.sv =====
// Datapath of the reservoir sampler: counters, divider, reservoir memory and output register.
module rsmp_dp
    import rsmp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 in_op,
    input  logic [ITEM_W-1:0]    in_item,
    input  logic [RND_W-1:0]     in_rnd,
    input  cmd_t                 cmd,
    output status_t              status,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [ITEM_W-1:0]    out_item,
    output logic                 out_flag,
    output logic                 out_last
);

    logic [CFG_W-1:0]  sample_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic [SEEN_W-1:0] seen_reg;
    logic [SEEN_W-1:0] seen_next;
    logic [ITEM_W-1:0] item_reg;
    logic [RND_W-1:0]  num_reg;
    logic [SEEN_W-1:0] rem_reg;
    logic [SEEN_W-1:0] rem_next;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic              out_valid_reg;
    logic [ITEM_W-1:0] out_item_reg;
    logic              out_flag_reg;
    logic              out_last_reg;

    logic [ITEM_W-1:0] mem [RES_DEPTH];

    logic [CNT_W-1:0]  cap;
    logic [SEEN_W:0]   rem_shift;
    logic              push_direct;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ITEM_W-1:0] wr_data;

    assign cap = (sample_reg > CFG_W'(RES_DEPTH)) ? CNT_W'(RES_DEPTH) : CNT_W'(sample_reg);

    assign seen_next = (seen_reg == '1) ? seen_reg : seen_reg + SEEN_W'(1);

    assign rem_shift = {rem_reg, num_reg[RND_W-1]};
    assign rem_next  = (rem_shift >= {1'b0, seen_reg}) ?
                       SEEN_W'(rem_shift - {1'b0, seen_reg}) : rem_shift[SEEN_W-1:0];

    assign push_direct = cmd.take && (in_op == OP_PUSH) && status.fill_lt_cap;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = fill_reg[ADDR_W-1:0];
        wr_data = in_item;
        if (push_direct)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.replace && (rem_reg < SEEN_W'(cap)))
        begin
            wr_en   = 1'b1;
            wr_addr = rem_reg[ADDR_W-1:0];
            wr_data = item_reg;
        end
    end

    assign status.fill_lt_cap = fill_reg < cap;
    assign status.div_last    = step_reg == LAST_STEP;
    assign status.out_free    = !out_valid_reg || out_ready;
    assign status.flush_last  = (fill_reg == '0) || ((idx_reg + CNT_W'(1)) == fill_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg    <= SAMPLE_RESET;
            fill_reg      <= '0;
            seen_reg      <= '0;
            step_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                sample_reg <= cfg_wdata;
            end
            if (cmd.take && (in_op == OP_PUSH))
            begin
                seen_reg <= seen_next;
            end
            if (push_direct)
            begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
            if (cmd.take)
            begin
                step_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
            if (cmd.flush_end)
            begin
                fill_reg <= '0;
                seen_reg <= '0;
                idx_reg  <= '0;
            end
            else if (cmd.flush_load)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            if (cmd.flush_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            item_reg <= in_item;
            num_reg  <= in_rnd;
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg <= {num_reg[RND_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.flush_load)
        begin
            if (fill_reg == '0)
            begin
                out_item_reg <= '0;
                out_flag_reg <= 1'b0;
                out_last_reg <= 1'b1;
            end
            else
            begin
                out_item_reg <= mem[idx_reg[ADDR_W-1:0]];
                out_flag_reg <= 1'b1;
                out_last_reg <= status.flush_last;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign out_flag  = out_flag_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== src/rsmp_checker.sv =====
// Port-level checker for the reservoir sampler and its bind to the top level.
module rsmp_checker
    import rsmp_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [ITEM_W-1:0]    m_axis_tdata,
    input logic                 m_axis_tuser,
    input logic                 m_axis_tlast
);

    // A stalled output word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // The empty flush word carries zero data and closes the flush.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("empty flush word malformed");

    // No input word is taken while a flush is still being emitted.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input accepted in the middle of a flush");

    // A push never produces an output word.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_PUSH) && !m_axis_tvalid
        |=> !m_axis_tvalid)
        else $error("output word appeared after a push");

endmodule

bind reservoir_sampler_unit rsmp_checker u_rsmp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
